FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the nearest feature point search.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_CLK(label, !(expr), msg)

`endif

FILE: rtl/nfps_pkg.sv
// Package for the nearest feature point search: sizes, codes and types.
// Used by nearest_feature_point_search; depends on nothing else.
package nfps_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 12;
   localparam int ADDR_BITS  = $clog2(MAX_POINTS);
   localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = 2 * COORD_BITS + 1;
   localparam int POINT_BITS = 2 * COORD_BITS;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

FILE: rtl/nearest_feature_point_search.sv
// Nearest feature point search: point store memory, scan pipeline and control.
// Depends on nfps_pkg and on assert_macros.svh.
//
// An item is taken when start is high and busy is low; its one result appears
// on the rsp_ ports for a single cycle with rsp_valid high and cannot be held
// off. Clear, add, the unused opcode and a query on an empty store answer in
// the cycle after the item is taken, and busy stays low. A query on a store of
// N points keeps busy high while the single read port of the point memory
// streams one point per cycle through a two-stage distance pipeline, and its
// result is registered on the rsp_ ports once the last point has been compared.
// Points are kept in load order and the earliest of equally near points wins.
`include "assert_macros.svh"

module nearest_feature_point_search
   import nfps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [COORD_BITS-1:0] rsp_nearest_x,
   output logic [COORD_BITS-1:0] rsp_nearest_y,
   output logic [DIST_BITS-1:0]  rsp_nearest_dist_sq
);

   logic [POINT_BITS-1:0] point_mem [MAX_POINTS];

   // Control state.
   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  issue_ff, issue_in;
   logic                   v1_ff, v1_in;
   logic                   last1_ff, last1_in;
   logic                   v2_ff, v2_in;
   logic                   last2_ff, last2_in;
   logic                   have_ff, have_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload.
   logic [POINT_BITS-1:0]  rdata_ff;
   logic [COORD_BITS-1:0]  pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0]  pixel_y_ff, pixel_y_in;
   logic [SQ_BITS-1:0]     sqx_ff, sqx_in;
   logic [SQ_BITS-1:0]     sqy_ff, sqy_in;
   logic [POINT_BITS-1:0]  pt2_ff, pt2_in;
   logic [DIST_BITS-1:0]   best_ff, best_in;
   logic [POINT_BITS-1:0]  best_pt_ff, best_pt_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [COORD_BITS-1:0]  rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]  rsp_y_ff, rsp_y_in;
   logic [DIST_BITS-1:0]   rsp_dist_ff, rsp_dist_in;

   logic                   accept;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr;
   logic [ADDR_BITS-1:0]   mem_raddr;
   logic [COORD_BITS-1:0]  rd_x, rd_y, dx, dy;
   logic [DIST_BITS-1:0]   cand_dist;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // First pipeline stage: absolute differences and their squares.
   assign rd_x   = rdata_ff[POINT_BITS-1:COORD_BITS];
   assign rd_y   = rdata_ff[COORD_BITS-1:0];
   assign dx     = (rd_x >= pixel_x_ff) ? (rd_x - pixel_x_ff) : (pixel_x_ff - rd_x);
   assign dy     = (rd_y >= pixel_y_ff) ? (rd_y - pixel_y_ff) : (pixel_y_ff - rd_y);
   assign sqx_in = SQ_BITS'(dx) * SQ_BITS'(dx);
   assign sqy_in = SQ_BITS'(dy) * SQ_BITS'(dy);
   assign pt2_in = rdata_ff;

   // Second pipeline stage: the distance that is compared against the best.
   assign cand_dist = DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);

   assign mem_raddr = issue_ff[ADDR_BITS-1:0];
   assign mem_waddr = count_ff[ADDR_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      v1_in         = 1'b0;
      last1_in      = last1_ff;
      v2_in         = v1_ff;
      last2_in      = last1_ff;
      have_in       = have_ff;
      rsp_valid_in  = 1'b0;
      pixel_x_in    = pixel_x_ff;
      pixel_y_in    = pixel_y_ff;
      best_in       = best_ff;
      best_pt_in    = best_pt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_dist_in   = rsp_dist_ff;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_dist_in   = '0;
               unique case (opcode_type'(req_opcode))
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_ADD: begin
                     if (count_ff == COUNT_BITS'(MAX_POINTS)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + COUNT_BITS'(1);
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        issue_in     = '0;
                        have_in      = 1'b0;
                        pixel_x_in   = req_pixel_x;
                        pixel_y_in   = req_pixel_y;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               v1_in    = 1'b1;
               last1_in = (issue_ff == count_ff - COUNT_BITS'(1));
               issue_in = issue_ff + COUNT_BITS'(1);
            end
            if (v2_ff) begin
               // Strict compare keeps the earliest of equally near points.
               if (!have_ff || cand_dist < best_ff) begin
                  best_in    = cand_dist;
                  best_pt_in = pt2_ff;
               end
               have_in = 1'b1;
               if (last2_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_x_in      = best_pt_in[POINT_BITS-1:COORD_BITS];
                  rsp_y_in      = best_pt_in[COORD_BITS-1:0];
                  rsp_dist_in   = best_in;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         v1_ff        <= 1'b0;
         last1_ff     <= 1'b0;
         v2_ff        <= 1'b0;
         last2_ff     <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         last1_ff     <= last1_in;
         v2_ff        <= v2_in;
         last2_ff     <= last2_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_x_ff    <= pixel_x_in;
      pixel_y_ff    <= pixel_y_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      pt2_ff        <= pt2_in;
      best_ff       <= best_in;
      best_pt_ff    <= best_pt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   // Point memory: one write port for adds, one registered read port for scans.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[mem_waddr] <= {req_point_x, req_point_y};
      end
      rdata_ff <= point_mem[mem_raddr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_nearest_x       = rsp_x_ff;
   assign rsp_nearest_y       = rsp_y_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;

   `ASSERT_NEVER(a_count_in_range, count_ff > COUNT_BITS'(MAX_POINTS), "point count overflow")
   `ASSERT_CLK(a_issue_bounded, (state_ff == ST_SCAN) |-> (issue_ff <= count_ff), "scan overran")
   `ASSERT_CLK(a_rsp_ends_scan, rsp_valid_ff |-> (state_ff == ST_IDLE), "result during scan")
   `ASSERT_CLK(a_quick_items_answer, (accept && (req_opcode != OP_QUERY || count_ff == '0)) |=> rsp_valid_ff, "no result")

endmodule
